// File: rtl/vending_controller_defines.svh
// ----------------------------------------------------------------------------
// vending_controller_defines
// Assertion macros used by the vending controller checker.
// ----------------------------------------------------------------------------
`ifndef VENDING_CONTROLLER_DEFINES_SVH
`define VENDING_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define VC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define VC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/vc_pkg.sv
// ----------------------------------------------------------------------------
// vc_pkg
// Types, codes and constants of the vending controller.
// ----------------------------------------------------------------------------
package vc_pkg;

  // Event codes
  localparam logic [2:0] FN_START   = 3'd0;
  localparam logic [2:0] FN_SELECT  = 3'd1;
  localparam logic [2:0] FN_COIN    = 3'd2;
  localparam logic [2:0] FN_ADMIN   = 3'd3;
  localparam logic [2:0] FN_RESTOCK = 3'd4;
  localparam logic [2:0] FN_EMPTY   = 3'd5;
  localparam logic [2:0] FN_EXIT    = 3'd6;

  // Status codes
  localparam logic [3:0] ST_IGNORED    = 4'd0;
  localparam logic [3:0] ST_SELECTED   = 4'd1;
  localparam logic [3:0] ST_NO_STOCK   = 4'd2;
  localparam logic [3:0] ST_NOT_ENOUGH = 4'd3;
  localparam logic [3:0] ST_DISPENSED  = 4'd4;
  localparam logic [3:0] ST_ADMIN      = 4'd5;
  localparam logic [3:0] ST_RESTOCKED  = 4'd6;
  localparam logic [3:0] ST_EMPTIED    = 4'd7;
  localparam logic [3:0] ST_EXITED     = 4'd8;
  localparam logic [3:0] ST_STARTED    = 4'd9;

  // Mode codes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_SEL   = 2'd1;
  localparam logic [1:0] MODE_MONEY = 2'd2;
  localparam logic [1:0] MODE_ADMIN = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_PRICE_COFFEE    = 3'd0;
  localparam logic [2:0] REG_PRICE_MOKKA     = 3'd1;
  localparam logic [2:0] REG_PRICE_CHOCO     = 3'd2;
  localparam logic [2:0] REG_PRICE_DISHWATER = 3'd3;
  localparam logic [2:0] REG_RESTOCK_LEVEL   = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int NUM_PRICES = 4;
  // Wide enough to compare a drink code with any drink count up to 32
  localparam int DRINK_IDX_W = 5;

  localparam logic [9:0]  PRICE_COFFEE_RST    = 10'd125;
  localparam logic [9:0]  PRICE_MOKKA_RST     = 10'd150;
  localparam logic [9:0]  PRICE_CHOCO_RST     = 10'd100;
  localparam logic [9:0]  PRICE_DISHWATER_RST = 10'd500;
  localparam logic [7:0]  RESTOCK_LEVEL_RST   = 8'd10;
  localparam logic [10:0] MONEY_MAX           = 11'd2047;
  localparam logic [19:0] CHANGE_MAX          = 20'hFFFFF;

  typedef logic [9:0] price_t;
  typedef price_t [NUM_PRICES-1:0] price_arr_t;

  typedef struct packed {
    logic [2:0] func;
    logic [1:0] drink;
    logic [1:0] coin;
  } vc_in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [1:0]  dispensed_drink;
    logic [10:0] change_given;
    logic [10:0] money_now;
    logic [1:0]  mode_now;
  } vc_out_t;

  function automatic logic [6:0] coin_value(input logic [1:0] code);
    logic [6:0] v;
    unique case (code)
      2'd0:    v = 7'd10;
      2'd1:    v = 7'd20;
      2'd2:    v = 7'd50;
      default: v = 7'd100;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/vc_core.sv
// ----------------------------------------------------------------------------
// vc_core
// Controller state and the combinational step that updates it per event.
// ----------------------------------------------------------------------------
module vc_core
  import vc_pkg::*;
#(
  parameter int NUM_DRINKS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  vc_in_t     item,
  input  price_arr_t prices,
  input  logic [7:0] restock_level,
  output vc_out_t    result
);

  logic [1:0]  mode, mode_next;
  logic [10:0] money_held, money_held_next;
  logic [1:0]  selected_drink, selected_drink_next;
  logic [19:0] change_total, change_total_next;
  logic [7:0]  stock      [NUM_DRINKS];
  logic [7:0]  stock_next [NUM_DRINKS];

  logic [NUM_DRINKS-1:0] hit_sel, hit_cur;
  logic        sel_in_stock;
  logic        drink_ok;
  logic [6:0]  coin_v;
  price_t      price;
  logic [11:0] money_sum;
  logic [10:0] money_sat;
  logic [20:0] ct_sum;
  logic [19:0] ct_sat;
  logic        paid;
  logic [10:0] change;
  logic [19:0] ct_after;

  always_comb begin
    sel_in_stock = 1'b0;
    for (int i = 0; i < NUM_DRINKS; i++) begin
      hit_sel[i] = (DRINK_IDX_W'(item.drink) == DRINK_IDX_W'(i));
      hit_cur[i] = (DRINK_IDX_W'(selected_drink) == DRINK_IDX_W'(i));
      sel_in_stock = sel_in_stock | (hit_sel[i] & (stock[i] != 8'd0));
    end
  end

  // Only codes below the drink count ever hit
  assign drink_ok  = |hit_sel;
  assign coin_v    = coin_value(item.coin);
  assign price     = prices[selected_drink];
  assign money_sum = {1'b0, money_held} + 12'(coin_v);
  assign money_sat = money_sum[11] ? MONEY_MAX : money_sum[10:0];
  assign ct_sum    = {1'b0, change_total} + 21'(coin_v);
  assign ct_sat    = ct_sum[20] ? CHANGE_MAX : ct_sum[19:0];
  assign paid      = money_sat >= {1'b0, price};
  assign change    = money_sat - {1'b0, price};
  assign ct_after  = (ct_sat >= 20'(change)) ? ct_sat - 20'(change) : '0;

  always_comb begin
    mode_next           = mode;
    money_held_next     = money_held;
    selected_drink_next = selected_drink;
    change_total_next   = change_total;
    for (int i = 0; i < NUM_DRINKS; i++) begin
      stock_next[i] = stock[i];
    end
    result = '0;

    case (item.func)
      FN_START: begin
        if (mode == MODE_IDLE) begin
          money_held_next = '0;
          mode_next       = MODE_SEL;
          result.status   = ST_STARTED;
        end
      end
      FN_SELECT: begin
        if (mode == MODE_SEL && drink_ok) begin
          if (sel_in_stock) begin
            selected_drink_next = item.drink;
            mode_next           = MODE_MONEY;
            result.status       = ST_SELECTED;
          end else begin
            result.status = ST_NO_STOCK;
          end
        end
      end
      FN_COIN: begin
        if (mode == MODE_MONEY) begin
          if (!paid) begin
            money_held_next   = money_sat;
            change_total_next = ct_sat;
            result.status     = ST_NOT_ENOUGH;
          end else begin
            change_total_next = ct_after;
            for (int i = 0; i < NUM_DRINKS; i++) begin
              if (hit_cur[i] && stock[i] != 8'd0) begin
                stock_next[i] = stock[i] - 8'd1;
              end
            end
            money_held_next        = '0;
            mode_next              = MODE_SEL;
            result.status          = ST_DISPENSED;
            result.dispensed_drink = selected_drink;
            result.change_given    = change;
          end
        end
      end
      FN_ADMIN: begin
        if (mode == MODE_SEL) begin
          mode_next     = MODE_ADMIN;
          result.status = ST_ADMIN;
        end
      end
      FN_RESTOCK: begin
        if (mode == MODE_ADMIN) begin
          for (int i = 0; i < NUM_DRINKS; i++) begin
            stock_next[i] = restock_level;
          end
          result.status = ST_RESTOCKED;
        end
      end
      FN_EMPTY: begin
        if (mode == MODE_ADMIN) begin
          change_total_next = '0;
          result.status     = ST_EMPTIED;
        end
      end
      FN_EXIT: begin
        if (mode == MODE_ADMIN) begin
          money_held_next = '0;
          mode_next       = MODE_SEL;
          result.status   = ST_EXITED;
        end
      end
      default: ;
    endcase

    result.money_now = money_held_next;
    result.mode_now  = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      money_held     <= '0;
      selected_drink <= '0;
      change_total   <= '0;
      for (int i = 0; i < NUM_DRINKS; i++) begin
        stock[i] <= '0;
      end
    end else if (fire) begin
      mode           <= mode_next;
      money_held     <= money_held_next;
      selected_drink <= selected_drink_next;
      change_total   <= change_total_next;
      for (int i = 0; i < NUM_DRINKS; i++) begin
        stock[i] <= stock_next[i];
      end
    end
  end

endmodule

// File: rtl/vending_controller.sv
// ----------------------------------------------------------------------------
// vending_controller
// Drink vending controller: one event in, one status result out.
// ----------------------------------------------------------------------------
// Takes one event per clock while the output is not stalled and returns exactly
// one result per event, in order. An accepted event is held in an input register,
// where the state update and the result are worked out together; the result is
// then captured in an output register once that register is free or draining.
// Throughput is one event per cycle while results are not stalled; a stalled
// result holds the input register and in turn stalls the input. The user must
// write prices and the restock level through the cfg port only while no event
// is in flight; the block itself does not enforce this.
module vending_controller
  import vc_pkg::*;
#(
  parameter int NUM_DRINKS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  vc_in_t                in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output vc_out_t               out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic       s1_valid;
  vc_in_t     s1_item;
  logic       advance;
  vc_out_t    step_result;
  price_arr_t prices;
  logic [7:0] restock_level;

  // Step the held event whenever the output register is free or draining
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prices[0]     <= PRICE_COFFEE_RST;
      prices[1]     <= PRICE_MOKKA_RST;
      prices[2]     <= PRICE_CHOCO_RST;
      prices[3]     <= PRICE_DISHWATER_RST;
      restock_level <= RESTOCK_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRICE_COFFEE:    prices[0]     <= cfg_data;
        REG_PRICE_MOKKA:     prices[1]     <= cfg_data;
        REG_PRICE_CHOCO:     prices[2]     <= cfg_data;
        REG_PRICE_DISHWATER: prices[3]     <= cfg_data;
        REG_RESTOCK_LEVEL:   restock_level <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  vc_core #(
    .NUM_DRINKS(NUM_DRINKS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (advance),
    .item         (s1_item),
    .prices       (prices),
    .restock_level(restock_level),
    .result       (step_result)
  );

endmodule

// File: rtl/vc_checker.sv
// ----------------------------------------------------------------------------
// vc_checker
// Port-level checks on the vending controller results.
// ----------------------------------------------------------------------------
`include "vending_controller_defines.svh"

module vc_checker
  import vc_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input logic    out_ready,
  input vc_out_t out_data
);

  // A stalled result beat holds
  `VC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

  // Dispense clears the money and returns to selection
  `VC_ASSERT_NOW(a_dispense_mode, out_valid && out_data.status == ST_DISPENSED, out_data.mode_now == MODE_SEL && out_data.money_now == 11'd0, "dispense left money or wrong mode")

  // Change and drink show only on a dispense
  `VC_ASSERT_NOW(a_change_only_dispense, out_valid && out_data.status != ST_DISPENSED, out_data.change_given == 11'd0 && out_data.dispensed_drink == 2'd0, "change or drink outside dispense")

  // Short payment keeps waiting for money with a coin counted
  `VC_ASSERT_NOW(a_not_enough, out_valid && out_data.status == ST_NOT_ENOUGH, out_data.mode_now == MODE_MONEY && out_data.money_now != 11'd0, "short payment in wrong mode")

endmodule

bind vending_controller vc_checker u_vc_checker (.*);

// File: bench/vending_controller_tb.sv
// ----------------------------------------------------------------------------
// vending_controller_tb
// Drives event beats into the vending controller with random idle gaps and
// output stalls, tracks the machine's mode, money, stock, change store and
// register settings alongside it, and checks every result beat against the
// state update it should cause. Short directed run first, then purchase-heavy
// random traffic over several price and restock settings.
// ----------------------------------------------------------------------------
module vending_controller_tb;
  import vc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_DRINKS  = 4;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 100;
  localparam int PHASE_BEATS = 80;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  vc_in_t                in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  vc_out_t               out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Machine state as the controller should hold it
  price_arr_t  price_now;
  logic [7:0]  refill_level;
  logic [1:0]  mode_q;
  logic [10:0] money_q;
  logic [1:0]  chosen_q;
  logic [7:0]  stock_left [NUM_DRINKS];
  logic [19:0] change_store;

  vc_in_t  event_queue[$];
  vc_out_t status_due[$];

  int errors        = 0;
  int events_done   = 0;
  int useful_done   = 0;
  int drinks_sold   = 0;
  int sold_out_hits = 0;
  int settings_run  = 0;
  bit idling_on     = 1'b1;
  bit hold_request  = 1'b0;
  int sender_gap    = 0;
  int sink_gap      = 0;
  int sink_hold     = 0;
  int quiet_cycles  = 0;

  vending_controller dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned coin_cents(input logic [1:0] code);
    case (code)
      2'd0:    return 10;
      2'd1:    return 20;
      2'd2:    return 50;
      default: return 100;
    endcase
  endfunction

  function automatic vc_in_t mk_event(input logic [2:0] fn, input logic [1:0] d,
                                      input logic [1:0] c);
    vc_in_t ev;
    ev.func  = fn;
    ev.drink = d;
    ev.coin  = c;
    return ev;
  endfunction

  // Apply one event to the tracked state and return the result it yields
  function automatic vc_out_t vend_event(input vc_in_t ev);
    vc_out_t     r;
    int unsigned sum;
    int unsigned total;
    int unsigned cost;
    int unsigned chg;
    r = '0;
    r.status = ST_IGNORED;
    case (ev.func)
      FN_START: if (mode_q == MODE_IDLE) begin
        money_q  = '0;
        mode_q   = MODE_SEL;
        r.status = ST_STARTED;
      end
      FN_SELECT: if (mode_q == MODE_SEL && int'(ev.drink) < NUM_DRINKS) begin
        if (stock_left[ev.drink] != 0) begin
          chosen_q = ev.drink;
          mode_q   = MODE_MONEY;
          r.status = ST_SELECTED;
        end else begin
          r.status = ST_NO_STOCK;
        end
      end
      FN_COIN: if (mode_q == MODE_MONEY) begin
        sum   = money_q + coin_cents(ev.coin);
        if (sum > MONEY_MAX) sum = MONEY_MAX;
        total = change_store + coin_cents(ev.coin);
        if (total > CHANGE_MAX) total = CHANGE_MAX;
        cost  = price_now[chosen_q];
        if (sum < cost) begin
          money_q  = sum[10:0];
          r.status = ST_NOT_ENOUGH;
        end else begin
          chg   = sum - cost;
          total = (total >= chg) ? total - chg : 0;
          if (stock_left[chosen_q] != 0) stock_left[chosen_q]--;
          r.dispensed_drink = chosen_q;
          r.change_given    = chg[10:0];
          money_q  = '0;
          mode_q   = MODE_SEL;
          r.status = ST_DISPENSED;
        end
        change_store = total[19:0];
      end
      FN_ADMIN: if (mode_q == MODE_SEL) begin
        mode_q   = MODE_ADMIN;
        r.status = ST_ADMIN;
      end
      FN_RESTOCK: if (mode_q == MODE_ADMIN) begin
        for (int i = 0; i < NUM_DRINKS; i++) stock_left[i] = refill_level;
        r.status = ST_RESTOCKED;
      end
      FN_EMPTY: if (mode_q == MODE_ADMIN) begin
        change_store = '0;
        r.status     = ST_EMPTIED;
      end
      FN_EXIT: if (mode_q == MODE_ADMIN) begin
        money_q  = '0;
        mode_q   = MODE_SEL;
        r.status = ST_EXITED;
      end
      default: ;
    endcase
    r.money_now = money_q;
    r.mode_now  = mode_q;
    return r;
  endfunction

  // Sender: one beat offered at a time, held until taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      sender_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        status_due.push_back(vend_event(in_data));
        events_done++;
        if (status_due[$].status != ST_IGNORED) useful_done++;
        if (status_due[$].status == ST_DISPENSED) drinks_sold++;
        if (status_due[$].status == ST_NO_STOCK) sold_out_hits++;
      end
      if (!in_valid || in_ready) begin
        if (sender_gap > 0) begin
          sender_gap--;
          in_valid <= 1'b0;
        end else if (event_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
          sender_gap = $urandom_range(1, 12) - 1;
          in_valid   <= 1'b0;
        end else begin
          in_data  <= event_queue.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Receiver: check each result beat, stall in bursts or one long hold
  always @(posedge clk) begin
    vc_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (status_due.size() == 0) begin
          $error("result beat with nothing outstanding: status %0d", out_data.status);
          errors++;
        end else begin
          want = status_due.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.dispensed_drink !== want.dispensed_drink) begin
            $error("dispensed_drink: expected %0d, actual %0d", want.dispensed_drink,
                   out_data.dispensed_drink);
            errors++;
          end
          if (out_data.change_given !== want.change_given) begin
            $error("change_given: expected %0d, actual %0d", want.change_given,
                   out_data.change_given);
            errors++;
          end
          if (out_data.money_now !== want.money_now) begin
            $error("money_now: expected %0d, actual %0d", want.money_now, out_data.money_now);
            errors++;
          end
          if (out_data.mode_now !== want.mode_now) begin
            $error("mode_now: expected %0d, actual %0d", want.mode_now, out_data.mode_now);
            errors++;
          end
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        sink_hold    = LONG_HOLD - 1;
        out_ready    <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        sink_gap  = $urandom_range(1, 12) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles with work outstanding but no beat moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (event_queue.size() == 0 && !in_valid && status_due.size() == 0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Recheck after an edge so a beat popped at the same edge is seen as pending
  task automatic drain();
    do begin
      while (event_queue.size() != 0 || in_valid || status_due.size() != 0) @(posedge clk);
      @(posedge clk);
    end while (event_queue.size() != 0 || in_valid || status_due.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PRICE_COFFEE:    price_now[0] = val;
      REG_PRICE_MOKKA:     price_now[1] = val;
      REG_PRICE_CHOCO:     price_now[2] = val;
      REG_PRICE_DISHWATER: price_now[3] = val;
      REG_RESTOCK_LEVEL:   refill_level = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [9:0] p0, input logic [9:0] p1, input logic [9:0] p2,
                           input logic [9:0] p3, input logic [7:0] lvl);
    write_reg(REG_PRICE_COFFEE, p0);
    write_reg(REG_PRICE_MOKKA, p1);
    write_reg(REG_PRICE_CHOCO, p2);
    write_reg(REG_PRICE_DISHWATER, p3);
    write_reg(REG_RESTOCK_LEVEL, {2'b00, lvl});
    settings_run++;
  endtask

  // Select a drink, then feed coins until its price is covered or the run is cut short
  task automatic queue_purchase(input logic [1:0] d, input bit cut_short);
    int unsigned paid;
    logic [1:0]  c;
    paid = 0;
    event_queue.push_back(mk_event(FN_SELECT, d, 2'($urandom_range(0, 3))));
    do begin
      c = 2'($urandom_range(0, 3));
      event_queue.push_back(mk_event(FN_COIN, 2'($urandom_range(0, 3)), c));
      paid += coin_cents(c);
      if (cut_short && $urandom_range(0, 2) == 0) break;
    end while (paid < price_now[d]);
  endtask

  task automatic queue_random_chunk();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      event_queue.push_back(mk_event(FN_ADMIN, 2'($urandom), 2'($urandom)));
      if ($urandom_range(0, 9) < 7)
        event_queue.push_back(mk_event(FN_RESTOCK, 2'($urandom), 2'($urandom)));
      if ($urandom_range(0, 9) < 4)
        event_queue.push_back(mk_event(FN_EMPTY, 2'($urandom), 2'($urandom)));
      event_queue.push_back(mk_event(FN_EXIT, 2'($urandom), 2'($urandom)));
    end else if (pick < 25) begin
      repeat ($urandom_range(1, 3))
        event_queue.push_back(mk_event(3'($urandom_range(0, 7)), 2'($urandom), 2'($urandom)));
    end else if (pick < 28) begin
      event_queue.push_back(mk_event(FN_START, 2'($urandom), 2'($urandom)));
    end else begin
      queue_purchase(2'($urandom_range(0, 3)), $urandom_range(0, 9) == 0);
    end
  endtask

  task automatic run_phase(input int beats, input bit long_hold);
    int goal;
    goal = events_done + beats;
    while (events_done + event_queue.size() < goal) begin
      queue_random_chunk();
      @(posedge clk);
      if (long_hold && event_queue.size() > 8) begin
        hold_request = 1'b1;
        long_hold    = 1'b0;
      end
      while (event_queue.size() > 8) @(posedge clk);
    end
    drain();
  endtask

  initial begin
    price_now    = {PRICE_DISHWATER_RST, PRICE_CHOCO_RST, PRICE_MOKKA_RST, PRICE_COFFEE_RST};
    refill_level = RESTOCK_LEVEL_RST;
    mode_q       = MODE_IDLE;
    money_q      = '0;
    chosen_q     = '0;
    change_store = '0;
    for (int i = 0; i < NUM_DRINKS; i++) stock_left[i] = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Wrong-mode events and the unused code while idle, then a full walk
    event_queue.push_back(mk_event(FN_COIN, 2'd0, 2'd3));
    event_queue.push_back(mk_event(FN_SELECT, 2'd3, 2'd0));
    event_queue.push_back(mk_event(FN_EXIT, 2'd0, 2'd0));
    event_queue.push_back(mk_event(3'd7, 2'd3, 2'd3));
    event_queue.push_back(mk_event(FN_START, 2'd0, 2'd0));
    event_queue.push_back(mk_event(FN_START, 2'd0, 2'd0));
    event_queue.push_back(mk_event(FN_SELECT, 2'd0, 2'd0));
    event_queue.push_back(mk_event(FN_RESTOCK, 2'd0, 2'd0));
    event_queue.push_back(mk_event(FN_ADMIN, 2'd0, 2'd0));
    event_queue.push_back(mk_event(FN_RESTOCK, 2'd0, 2'd0));
    event_queue.push_back(mk_event(FN_EMPTY, 2'd0, 2'd0));
    event_queue.push_back(mk_event(FN_EXIT, 2'd0, 2'd0));
    event_queue.push_back(mk_event(FN_SELECT, 2'd3, 2'd0));
    event_queue.push_back(mk_event(FN_SELECT, 2'd1, 2'd0));
    event_queue.push_back(mk_event(FN_ADMIN, 2'd0, 2'd0));
    repeat (5) event_queue.push_back(mk_event(FN_COIN, 2'd0, 2'd3));
    event_queue.push_back(mk_event(FN_SELECT, 2'd1, 2'd0));
    event_queue.push_back(mk_event(FN_COIN, 2'd0, 2'd2));
    event_queue.push_back(mk_event(FN_COIN, 2'd0, 2'd0));
    drain();

    // Lower the price under the money already held; next coin must dispense
    write_reg(REG_PRICE_MOKKA, 10'd40);
    event_queue.push_back(mk_event(FN_COIN, 2'd0, 2'd1));
    drain();

    for (int k = 0; k < 6; k++) begin
      case (k)
        0: write_all(10'd0, 10'd1023, 10'($urandom_range(0, 1023)),
                     10'($urandom_range(0, 1023)), 8'd255);
        1: write_all(10'($urandom_range(0, 300)), 10'($urandom_range(0, 300)),
                     10'($urandom_range(0, 300)), 10'($urandom_range(0, 1023)),
                     8'($urandom_range(1, 40)));
        2: write_all(10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'd0);
        3: write_all(10'd0, 10'd0, 10'd0, 10'd0, 8'd1);
        4: write_all(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                     10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                     8'($urandom_range(0, 255)));
        default: write_all(10'($urandom_range(0, 400)), 10'($urandom_range(0, 400)),
                           10'($urandom_range(0, 400)), 10'($urandom_range(0, 400)),
                           8'($urandom_range(2, 60)));
      endcase
      idling_on = (k != 5);
      run_phase(PHASE_BEATS, k == 4);
    end

    repeat (10) @(posedge clk);
    $display("Ran %0d events (%0d acted on) over %0d register settings", events_done,
             useful_done, settings_run);
    $display("%0d drinks dispensed, %0d sold-out selections", drinks_sold, sold_out_hits);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
